// File: hw/rtl/text_console_writer_defines.svh
// assertion macros for the text console writer
// used by text_console_writer.sv; needs clk and rst in the including scope
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, off while reset is high
`define TCW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also during reset
`define TCW_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(name, prop, msg)
`define TCW_ASSERT_RST(name, prop, msg)
`endif

`endif

// File: hw/rtl/tcw_pkg.sv
// shared types and constants of the text console writer
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int ACTION_W    = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = 16;
  localparam int ADDR_IN_W   = 11;
  localparam int CURSOR_OUT_W = 11;
  localparam int COUNT_W     = 16;
  localparam int CFG_INDEX_W = 2;

  typedef logic [ACTION_W-1:0]    action_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // action codes
  localparam action_t ACT_PUT   = 2'd0;
  localparam action_t ACT_CLEAR = 2'd1;
  localparam action_t ACT_READ  = 2'd2;

  // register indexes
  localparam cfg_index_t REG_TEXT_ATTR  = 2'd0;
  localparam cfg_index_t REG_CLEAR_ATTR = 2'd1;

  // character codes and reset values
  localparam logic [CHAR_W-1:0]  NUL_CHAR         = 8'h00;
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR     = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR       = 8'h20;
  localparam logic [ATTR_W-1:0]  TEXT_ATTR_RESET  = 8'h0F;
  localparam logic [ATTR_W-1:0]  CLEAR_ATTR_RESET = 8'h07;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

  // controller states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_COPY,
    S_FILL,
    S_CLEAR,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/tcw_channels.sv
// valid/ready channel interfaces of the text console writer
// depends on tcw_pkg for field widths
`timescale 1ns / 1ps

// command channel
interface tcw_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [tcw_pkg::ACTION_W-1:0]    action;
  logic [tcw_pkg::CHAR_W-1:0]      character;
  logic [tcw_pkg::ADDR_IN_W-1:0]   cell_address;
  modport source (output valid, action, character, cell_address, input ready);
  modport sink (input valid, action, character, cell_address, output ready);
endinterface

// result channel
interface tcw_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [tcw_pkg::CURSOR_OUT_W-1:0]  cursor_position;
  logic                              scrolled;
  logic [tcw_pkg::CELL_W-1:0]        cell_data;
  logic [tcw_pkg::COUNT_W-1:0]       line_char_count;
  modport source (output valid, cursor_position, scrolled, cell_data, line_char_count,
                  input ready);
  modport sink (input valid, cursor_position, scrolled, cell_data, line_char_count,
                output ready);
endinterface

// register write channel
interface tcw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tcw_pkg::CFG_INDEX_W-1:0]  index;
  logic [tcw_pkg::ATTR_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/text_console_writer.sv
// text console writer: screen memory, cursor and scroll/clear sequencer
// depends on tcw_pkg, tcw_channels.sv and text_console_writer_defines.svh
`timescale 1ns / 1ps

// Text console of COLUMNS x ROWS 16-bit cells (attribute high byte, character
// low byte) held in one single-port-write, one-read memory with a registered
// read. After reset the block runs a clearing pass over all cells with
// cmd.ready low; register writes are taken at any time. A put or newline
// that scrolls, and clear screen, pass over every cell: the memory moves or
// writes one cell per cycle. One item is handled at a time; the result
// register lets the block finish an item while the previous result waits.

`include "text_console_writer_defines.svh"

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  tcw_cmd_if.sink    cmd,
  tcw_rsp_if.source  rsp,
  tcw_cfg_if.sink    cfg
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int OW    = (CW > tcw_pkg::ADDR_IN_W) ? CW : tcw_pkg::ADDR_IN_W;
  localparam int COL_W = $clog2(COLUMNS);
  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]    COPY_LAST = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0]    COLS_AW   = AW'(COLUMNS);
  localparam logic [CW-1:0]    CELLS_CW  = CW'(CELLS);
  localparam logic [CW-1:0]    COLS_CW   = CW'(COLUMNS);
  localparam logic [OW-1:0]    CELLS_OW  = OW'(CELLS);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

  // state registers
  tcw_pkg::state_t state, state_next;
  logic [CW-1:0]    cursor;
  logic [COL_W-1:0] col;
  logic [tcw_pkg::COUNT_W-1:0] line_count;
  logic [tcw_pkg::ATTR_W-1:0]  text_attr;
  logic [tcw_pkg::ATTR_W-1:0]  clear_attr;
  logic [AW-1:0]    idx;
  logic [tcw_pkg::CELL_W-1:0]  fill_value;
  logic             item_scrolled;
  logic             item_read_ok;

  // delayed write port
  logic             wr_pend;
  logic             wr_use_rd;
  logic [AW-1:0]    wr_addr;
  logic [tcw_pkg::CELL_W-1:0]  wr_val;

  // screen memory
  logic [tcw_pkg::CELL_W-1:0]  mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0]  rd_data;
  logic             mem_re;
  logic [AW-1:0]    mem_ra;
  logic [tcw_pkg::CELL_W-1:0]  mem_wd;

  // result register
  logic             out_valid;
  logic [tcw_pkg::CURSOR_OUT_W-1:0] out_cursor;
  logic             out_scrolled;
  logic [tcw_pkg::CELL_W-1:0]  out_data;
  logic [tcw_pkg::COUNT_W-1:0] out_count;

  // handshake and decode
  logic             cmd_ready;
  logic             cmd_accept;
  logic             load_out;
  logic [OW-1:0]    addr_wide;
  logic             addr_ok;
  logic             is_nl;
  logic             is_nul;
  logic [CW-1:0]    cursor_inc;
  logic [CW-1:0]    cursor_nl;
  logic [CW-1:0]    cursor_new;
  logic             need_scroll;
  logic [OW-1:0]    cursor_wide;

  // put character arithmetic
  always_comb begin
    is_nl       = (cmd.character == tcw_pkg::NEWLINE_CHAR);
    is_nul      = (cmd.character == tcw_pkg::NUL_CHAR);
    cursor_inc  = cursor + CW'(1);
    cursor_nl   = cursor + COLS_CW - CW'(col);
    cursor_new  = is_nl ? cursor_nl : cursor_inc;
    need_scroll = (cursor_new == CELLS_CW);
    addr_wide   = OW'(cmd.cell_address);
    addr_ok     = (addr_wide < CELLS_OW);
    cursor_wide = OW'(cursor);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::S_INIT: begin
        if (idx == LAST_CELL) state_next = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (cmd_accept) begin
          case (cmd.action)
            tcw_pkg::ACT_PUT: begin
              if (!is_nul && need_scroll) state_next = tcw_pkg::S_COPY;
              else state_next = tcw_pkg::S_DONE;
            end
            tcw_pkg::ACT_CLEAR: state_next = tcw_pkg::S_CLEAR;
            default: state_next = tcw_pkg::S_DONE;
          endcase
        end
      end
      tcw_pkg::S_COPY: begin
        if (idx == COPY_LAST) state_next = tcw_pkg::S_FILL;
      end
      tcw_pkg::S_FILL: begin
        if (idx == LAST_CELL) state_next = tcw_pkg::S_DONE;
      end
      tcw_pkg::S_CLEAR: begin
        if (idx == LAST_CELL) state_next = tcw_pkg::S_DONE;
      end
      tcw_pkg::S_DONE: begin
        if (load_out) state_next = tcw_pkg::S_IDLE;
      end
      default: state_next = tcw_pkg::S_INIT;
    endcase
  end

  // state outputs: handshake and memory read port
  always_comb begin
    cmd_ready  = (state == tcw_pkg::S_IDLE) && !wr_pend;
    cmd_accept = cmd.valid && cmd_ready;
    load_out   = 1'b0;
    mem_re     = 1'b0;
    mem_ra     = '0;
    case (state)
      tcw_pkg::S_IDLE: begin
        if (cmd_accept && cmd.action == tcw_pkg::ACT_READ && addr_ok) begin
          mem_re = 1'b1;
          mem_ra = addr_wide[AW-1:0];
        end
      end
      tcw_pkg::S_COPY: begin
        mem_re = 1'b1;
        mem_ra = idx + COLS_AW;
      end
      tcw_pkg::S_DONE: begin
        load_out = !out_valid || rsp.ready;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::S_INIT;
      idx        <= '0;
      wr_pend    <= 1'b0;
      cursor     <= '0;
      col        <= '0;
      line_count <= '0;
      text_attr  <= tcw_pkg::TEXT_ATTR_RESET;
      clear_attr <= tcw_pkg::CLEAR_ATTR_RESET;
      fill_value <= {tcw_pkg::CLEAR_ATTR_RESET, tcw_pkg::BLANK_CHAR};
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // register writes
      if (cfg.valid) begin
        case (cfg.index)
          tcw_pkg::REG_TEXT_ATTR:  text_attr  <= cfg.data;
          tcw_pkg::REG_CLEAR_ATTR: clear_attr <= cfg.data;
          default: ;
        endcase
      end

      case (state)
        tcw_pkg::S_INIT, tcw_pkg::S_CLEAR, tcw_pkg::S_COPY, tcw_pkg::S_FILL: begin
          wr_pend <= 1'b1;
          idx     <= idx + AW'(1);
        end
        tcw_pkg::S_IDLE: begin
          // a character other than NUL or newline writes its cell in the next cycle, through wr_pend
          wr_pend <= cmd_accept && (cmd.action == tcw_pkg::ACT_PUT) && !is_nul && !is_nl;
          if (cmd_accept) begin
            idx <= '0;
            case (cmd.action)
              tcw_pkg::ACT_PUT: begin
                if (!is_nul) begin
                  cursor <= need_scroll ? cursor_new - COLS_CW : cursor_new;
                  if (is_nl) begin
                    col        <= '0;
                    line_count <= '0;
                  end else begin
                    col <= (col == COL_LAST) ? '0 : col + COL_W'(1);
                    if (line_count != tcw_pkg::COUNT_MAX)
                      line_count <= line_count + tcw_pkg::COUNT_W'(1);
                  end
                end
              end
              tcw_pkg::ACT_CLEAR: begin
                fill_value <= {clear_attr, tcw_pkg::BLANK_CHAR};
              end
              default: ;
            endcase
          end
        end
        default: begin
          wr_pend <= 1'b0;
        end
      endcase

      // result register valid
      if (load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      tcw_pkg::S_INIT, tcw_pkg::S_CLEAR: begin
        wr_use_rd <= 1'b0;
        wr_addr   <= idx;
        wr_val    <= fill_value;
      end
      tcw_pkg::S_COPY: begin
        wr_use_rd <= 1'b1;
        wr_addr   <= idx;
      end
      tcw_pkg::S_FILL: begin
        wr_use_rd <= 1'b0;
        wr_addr   <= idx;
        wr_val    <= {text_attr, tcw_pkg::BLANK_CHAR};
      end
      tcw_pkg::S_IDLE: begin
        if (cmd_accept) begin
          wr_use_rd     <= 1'b0;
          wr_addr       <= cursor[AW-1:0];
          wr_val        <= {text_attr, cmd.character};
          item_scrolled <= (cmd.action == tcw_pkg::ACT_PUT) && !is_nul && need_scroll;
          item_read_ok  <= (cmd.action == tcw_pkg::ACT_READ) && addr_ok;
        end
      end
      default: ;
    endcase

    if (load_out) begin
      out_cursor   <= cursor_wide[tcw_pkg::CURSOR_OUT_W-1:0];
      out_scrolled <= item_scrolled;
      out_data     <= item_read_ok ? rd_data : '0;
      out_count    <= line_count;
    end
  end

  // screen memory, one write and one registered read per cycle
  assign mem_wd = wr_use_rd ? rd_data : wr_val;

  always_ff @(posedge clk) begin
    if (wr_pend) mem[wr_addr] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

  // ports
  assign cmd.ready           = cmd_ready;
  assign cfg.ready           = 1'b1;
  assign rsp.valid           = out_valid;
  assign rsp.cursor_position = out_cursor;
  assign rsp.scrolled        = out_scrolled;
  assign rsp.cell_data       = out_data;
  assign rsp.line_char_count = out_count;

  // checks
  `TCW_ASSERT(a_cursor_in_range, cursor < CELLS_CW, "cursor left the screen")
  `TCW_ASSERT(a_col_in_range, col <= COL_LAST, "column tracker out of range")
  `TCW_ASSERT(a_accept_leaves_idle, cmd_accept |=> (state != tcw_pkg::S_IDLE), "accepted item not started")
  `TCW_ASSERT(a_copy_follows_read, (wr_pend && wr_use_rd) |-> $past(mem_re), "copy write without read")
  `TCW_ASSERT_RST(a_no_accept_in_init, (state == tcw_pkg::S_INIT) |-> !cmd_ready, "ready during clearing pass")

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the text console writer (80x25 screen, cursor, scroll)
// depends on tcw_pkg, the channel interfaces in tcw_channels.sv and text_console_writer
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int SCREEN_SIZE = COLS * ROWS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam action_t ACT_UNUSED = 2'd3;

  typedef struct packed {
    action_t                 action;
    logic [CHAR_W-1:0]       character;
    logic [ADDR_IN_W-1:0]    cell_address;
  } console_cmd_t;

  typedef struct packed {
    logic [CURSOR_OUT_W-1:0] cursor_position;
    logic                    scrolled;
    logic [CELL_W-1:0]       cell_data;
    logic [COUNT_W-1:0]      line_char_count;
  } console_status_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcw_cmd_if cmd_ch ();
  tcw_rsp_if rsp_ch ();
  tcw_cfg_if cfg_ch ();

  text_console_writer #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // shadow copy of the console
  logic [CELL_W-1:0] screen_model [0:SCREEN_SIZE-1];
  int unsigned       cursor_model;
  int unsigned       line_count_model;
  logic [ATTR_W-1:0] text_attr_model;
  logic [ATTR_W-1:0] clear_attr_model;

  console_cmd_t    cmd_pending_q [$];
  console_status_t expected_status_q [$];

  int unsigned     mismatch_count = 0;
  int unsigned     results_seen = 0;
  int unsigned     quiet_cycles = 0;

  // driver bookkeeping
  int unsigned     burst_left = 0;
  int unsigned     gap_left = 0;
  logic            cmd_taken;
  console_cmd_t    cmd_sent;

  // receiver bookkeeping
  rx_mode_e        rx_mode = RX_STREAM;
  int unsigned     rx_seg_left = 0;
  int unsigned     hold_left = 0;
  logic            long_hold_done = 1'b0;

  // monitor bookkeeping
  console_status_t status_got;
  console_status_t status_want;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void reset_console_model();
    int k;
    text_attr_model  = TEXT_ATTR_RESET;
    clear_attr_model = CLEAR_ATTR_RESET;
    cursor_model     = 0;
    line_count_model = 0;
    for (k = 0; k < SCREEN_SIZE; k++) begin
      screen_model[k] = {CLEAR_ATTR_RESET, BLANK_CHAR};
    end
  endfunction

  // scroll up one row once the cursor runs off the bottom
  function automatic logic scroll_console_model();
    int k;
    if (cursor_model < SCREEN_SIZE) return 1'b0;
    for (k = 0; k < SCREEN_SIZE - COLS; k++) begin
      screen_model[k] = screen_model[k + COLS];
    end
    for (k = SCREEN_SIZE - COLS; k < SCREEN_SIZE; k++) begin
      screen_model[k] = {text_attr_model, BLANK_CHAR};
    end
    cursor_model -= COLS;
    return 1'b1;
  endfunction

  // apply one command to the shadow console and return its status
  function automatic console_status_t apply_console_cmd(console_cmd_t c);
    console_status_t r;
    int k;
    r = '0;
    case (c.action)
      ACT_PUT: begin
        if (c.character == NEWLINE_CHAR) begin
          cursor_model += COLS - (cursor_model % COLS);
          line_count_model = 0;
          r.scrolled = scroll_console_model();
        end else if (c.character != NUL_CHAR) begin
          if (cursor_model < SCREEN_SIZE) begin
            screen_model[cursor_model] = {text_attr_model, c.character};
          end
          cursor_model++;
          if (line_count_model < COUNT_MAX) line_count_model++;
          r.scrolled = scroll_console_model();
        end
      end
      ACT_CLEAR: begin
        for (k = 0; k < SCREEN_SIZE; k++) begin
          screen_model[k] = {clear_attr_model, BLANK_CHAR};
        end
      end
      ACT_READ: begin
        if (c.cell_address < SCREEN_SIZE) r.cell_data = screen_model[c.cell_address];
      end
      default: ;
    endcase
    r.cursor_position = cursor_model[CURSOR_OUT_W-1:0];
    r.line_char_count = line_count_model[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void add_cmd(action_t act, logic [CHAR_W-1:0] ch,
                                  logic [ADDR_IN_W-1:0] addr);
    console_cmd_t c;
    c.action       = act;
    c.character    = ch;
    c.cell_address = addr;
    cmd_pending_q.push_back(c);
  endfunction

  // random command mix, weighted toward text and newlines to reach scrolling
  function automatic console_cmd_t random_console_cmd();
    console_cmd_t c;
    int unsigned pick;
    pick           = $urandom_range(0, 99);
    c.action       = ACT_PUT;
    c.character    = CHAR_W'($urandom_range(0, 255));
    c.cell_address = ADDR_IN_W'($urandom_range(0, 2047));
    if (pick < 50) begin
      c.character = CHAR_W'($urandom_range(1, 255));
    end else if (pick < 72) begin
      c.character = NEWLINE_CHAR;
    end else if (pick < 75) begin
      c.character = NUL_CHAR;
    end else if (pick < 93) begin
      c.action = ACT_READ;
      case ($urandom_range(0, 9))
        0:       c.cell_address = ADDR_IN_W'($urandom_range(SCREEN_SIZE, 2047));
        1, 2, 3: c.cell_address =
                   ADDR_IN_W'($urandom_range(SCREEN_SIZE - 2 * COLS, SCREEN_SIZE - 1));
        default: c.cell_address = ADDR_IN_W'($urandom_range(0, SCREEN_SIZE - 1));
      endcase
    end else if (pick < 97) begin
      c.action = ACT_UNUSED;
    end else begin
      c.action = ACT_CLEAR;
    end
    return c;
  endfunction

  task automatic write_console_reg(cfg_index_t idx, logic [ATTR_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_TEXT_ATTR) text_attr_model = value;
    else if (idx == REG_CLEAR_ATTR) clear_attr_model = value;
  endtask

  task automatic wait_console_idle();
    do @(posedge clk);
    while (cmd_pending_q.size() != 0 || expected_status_q.size() != 0 || cmd_ch.valid);
    repeat (4) @(posedge clk);
  endtask

  // command driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      cmd_taken = cmd_ch.valid && cmd_ch.ready;
      if (cmd_taken) begin
        cmd_sent.action       = cmd_ch.action;
        cmd_sent.character    = cmd_ch.character;
        cmd_sent.cell_address = cmd_ch.cell_address;
        expected_status_q.push_back(apply_console_cmd(cmd_sent));
        void'(cmd_pending_q.pop_front());
      end
      // keep offering until the transaction goes through
      if (!(cmd_ch.valid && !cmd_taken)) begin
        if (gap_left != 0) begin
          cmd_ch.valid <= 1'b0;
          gap_left--;
        end else if (cmd_pending_q.size() != 0) begin
          cmd_ch.valid        <= 1'b1;
          cmd_ch.action       <= cmd_pending_q[0].action;
          cmd_ch.character    <= cmd_pending_q[0].character;
          cmd_ch.cell_address <= cmd_pending_q[0].cell_address;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: stall pattern in segments, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (!long_hold_done && results_seen >= 40) begin
        hold_left      = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (rx_seg_left == 0) begin
          rx_mode     = rx_mode_e'($urandom_range(0, 2));
          rx_seg_left = $urandom_range(4, 60);
        end else begin
          rx_seg_left--;
        end
        case (rx_mode)
          RX_STREAM: rsp_ch.ready <= 1'b1;
          RX_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
          default:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result monitor: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      status_got.cursor_position = rsp_ch.cursor_position;
      status_got.scrolled        = rsp_ch.scrolled;
      status_got.cell_data       = rsp_ch.cell_data;
      status_got.line_char_count = rsp_ch.line_char_count;
      if (expected_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: unexpected result cursor=%0d scrolled=%0b data=%04h count=%0d",
                   $realtime, status_got.cursor_position, status_got.scrolled,
                   status_got.cell_data, status_got.line_char_count);
        end
      end else begin
        status_want = expected_status_q.pop_front();
        if (status_got.cursor_position !== status_want.cursor_position ||
            status_got.scrolled !== status_want.scrolled ||
            status_got.cell_data !== status_want.cell_data ||
            status_got.line_char_count !== status_want.line_char_count) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result %0d mismatch: exp cursor=%0d scrolled=%0b data=%04h count=%0d",
                     $realtime, results_seen, status_want.cursor_position,
                     status_want.scrolled, status_want.cell_data,
                     status_want.line_char_count);
            $display("%0t: result %0d mismatch: got cursor=%0d scrolled=%0b data=%04h count=%0d",
                     $realtime, results_seen, status_got.cursor_position,
                     status_got.scrolled, status_got.cell_data,
                     status_got.line_char_count);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("text_console_writer regression: fail");
        $finish;
      end
    end
  end

  // stimulus phases
  initial begin
    cmd_ch.valid        = 1'b0;
    cmd_ch.action       = ACT_PUT;
    cmd_ch.character    = NUL_CHAR;
    cmd_ch.cell_address = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_TEXT_ATTR;
    cfg_ch.data         = '0;
    rsp_ch.ready        = 1'b0;
    reset_console_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, range edges, every action, nul and newline
    add_cmd(ACT_READ, NUL_CHAR, 11'd0);
    add_cmd(ACT_READ, NUL_CHAR, 11'd1999);
    add_cmd(ACT_READ, 8'hFF, 11'd2047);
    add_cmd(ACT_READ, NUL_CHAR, 11'd2000);
    add_cmd(ACT_PUT, 8'h41, 11'd0);
    add_cmd(ACT_PUT, 8'hFF, 11'd2047);
    add_cmd(ACT_PUT, 8'h01, 11'd0);
    add_cmd(ACT_PUT, NUL_CHAR, 11'd0);
    add_cmd(ACT_UNUSED, 8'hFF, 11'd2047);
    add_cmd(ACT_READ, NUL_CHAR, 11'd0);
    add_cmd(ACT_READ, NUL_CHAR, 11'd1);
    add_cmd(ACT_READ, NUL_CHAR, 11'd2);
    add_cmd(ACT_READ, NUL_CHAR, 11'd3);
    add_cmd(ACT_PUT, NEWLINE_CHAR, 11'd0);
    add_cmd(ACT_PUT, 8'h7E, 11'd0);
    add_cmd(ACT_PUT, NEWLINE_CHAR, 11'd0);
    add_cmd(ACT_READ, NUL_CHAR, 11'd80);
    add_cmd(ACT_CLEAR, 8'hFF, 11'd2047);
    add_cmd(ACT_READ, NUL_CHAR, 11'd0);
    add_cmd(ACT_READ, NUL_CHAR, 11'd80);
    add_cmd(ACT_PUT, 8'h80, 11'd0);
    wait_console_idle();

    // extreme attributes, one way round
    write_console_reg(REG_TEXT_ATTR, 8'h00);
    write_console_reg(REG_CLEAR_ATTR, 8'hFF);
    add_cmd(ACT_CLEAR, NUL_CHAR, 11'd0);
    add_cmd(ACT_READ, NUL_CHAR, 11'd1999);
    repeat (150) cmd_pending_q.push_back(random_console_cmd());
    wait_console_idle();

    // extreme attributes, the other way round
    write_console_reg(REG_TEXT_ATTR, 8'hFF);
    write_console_reg(REG_CLEAR_ATTR, 8'h00);
    add_cmd(ACT_CLEAR, NUL_CHAR, 11'd0);
    add_cmd(ACT_READ, NUL_CHAR, 11'd0);
    repeat (150) cmd_pending_q.push_back(random_console_cmd());
    wait_console_idle();

    // random attributes
    write_console_reg(REG_TEXT_ATTR, ATTR_W'($urandom_range(0, 255)));
    write_console_reg(REG_CLEAR_ATTR, ATTR_W'($urandom_range(0, 255)));
    repeat (130) cmd_pending_q.push_back(random_console_cmd());
    wait_console_idle();

    // long line without newline, wrapping across rows
    write_console_reg(REG_TEXT_ATTR, ATTR_W'($urandom_range(0, 255)));
    repeat (90) add_cmd(ACT_PUT, CHAR_W'($urandom_range(11, 255)),
                        ADDR_IN_W'($urandom_range(0, 2047)));
    add_cmd(ACT_READ, NUL_CHAR, ADDR_IN_W'(SCREEN_SIZE - 1));
    add_cmd(ACT_PUT, NEWLINE_CHAR, 11'd0);
    add_cmd(ACT_PUT, 8'h5A, 11'd0);
    wait_console_idle();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

endmodule
